[design/dvr_pkg.sv]
// ----------------------------------------------------------------------------
// dvr_pkg: shared types and codes for the distance-vector route solver
// Command and status records passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dvr_pkg;

	// Fixed field widths of the ports
	localparam int NODE_W = 3;
	localparam int LINK_W = 10;
	localparam int DIST_W = 10;
	localparam int NC_W   = 4;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [2:0]        op_t;

	// Datapath operation codes
	localparam op_t OP_NOP  = 3'd0;
	localparam op_t OP_CLR  = 3'd1;  // clear the change flag at pass start
	localparam op_t OP_SELF = 3'd2;  // fetch current distance and hop of (r, d)
	localparam op_t OP_VIA  = 3'd3;  // relax (r, d) through node v
	localparam op_t OP_WB   = 3'd4;  // write back (r, d) if it improved
	localparam op_t OP_DUMP = 3'd5;  // read (r, d) into the result register

	typedef struct packed {
		op_t   op;
		node_t r;
		node_t d;
		node_t v;
		logic  last;  // final table entry, used by the dump
		logic  load;  // input transaction accepted this cycle
	} cmd_t;

	typedef struct packed {
		logic out_free;  // result register can take a new entry next cycle
		logic changed;   // some entry improved during the current pass
	} stat_t;

endpackage

[design/distance_vector_route_solver_core.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_solver_core: Bellman-Ford distance-vector solver
// Loads a link-cost matrix, relaxes the routing table until stable and
// streams out every (router, destination) entry.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we                    cfg_wdata (node count)
//   item     in         item_valid / item_stall   source_node, target_node,
//                                                  link_cost, last_entry
//   result   out        result_valid / result_stall router, destination,
//                                                  next_hop, distance, last_result
//
// Matrix entries load one per cycle. After the last entry each pass relaxes
// every (router, destination) pair of the N active nodes through every via
// node, one via check per cycle through the shared add/compare; passes repeat
// until one makes no change. The dump reads the next entry only once the last
// one has passed stage 1 and the result register is free or being read.
// Reset needs no memory clearing pass; the node count resets to 8.
// item_stall is high from the cycle after the last entry until the final
// table entry has been read for the dump.
// ----------------------------------------------------------------------------
module distance_vector_route_solver_core #(
	parameter int MAX_NODES = 8,
	parameter int COST_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dvr_pkg::NC_W-1:0]   cfg_wdata,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [dvr_pkg::NODE_W-1:0] source_node,
	input  logic [dvr_pkg::NODE_W-1:0] target_node,
	input  logic [dvr_pkg::LINK_W-1:0] link_cost,
	input  logic                       last_entry,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [dvr_pkg::NODE_W-1:0] router,
	output logic [dvr_pkg::NODE_W-1:0] destination,
	output logic [dvr_pkg::NODE_W-1:0] next_hop,
	output logic [dvr_pkg::DIST_W-1:0] distance,
	output logic                       last_result
);
	import dvr_pkg::*;

	cmd_t  dp_cmd;
	stat_t dp_stat;

	dvr_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.last_entry (last_entry),
		.item_stall (item_stall),
		.cmd        (dp_cmd),
		.stat       (dp_stat)
	);

	dvr_dpath #(
		.MAX_NODES (MAX_NODES),
		.COST_BITS (COST_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_node  (source_node),
		.target_node  (target_node),
		.link_cost    (link_cost),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.router       (router),
		.destination  (destination),
		.next_hop     (next_hop),
		.distance     (distance),
		.last_result  (last_result)
	);

	// The final matrix entry closes the input until the dump completes
	a_last_entry_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && last_entry) |=> item_stall)
		else $error("input not stalled after last matrix entry");

	// Nothing follows the final table entry
	a_last_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && last_result) |=> !result_valid)
		else $error("result presented after final table entry");

	// A dump read is only issued when the result register will be free
	a_dump_room: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == OP_DUMP) |-> (!result_valid || !result_stall))
		else $error("dump issued while result register is held");

endmodule

[design/dvr_ctrl.sv]
// ----------------------------------------------------------------------------
// dvr_ctrl: sequencer for the route solver
// Holds the node count, loads the matrix, walks the relaxation passes over
// router, destination and via, repeats until a pass is clean, then dumps.
// ----------------------------------------------------------------------------
module dvr_ctrl #(
	parameter int MAX_NODES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dvr_pkg::NC_W-1:0]  cfg_wdata,
	input  logic                      item_valid,
	input  logic                      last_entry,
	output logic                      item_stall,
	output dvr_pkg::cmd_t             cmd,
	input  dvr_pkg::stat_t            stat
);
	import dvr_pkg::*;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_SELF  = 3'd2;
	localparam logic [2:0] ST_VIA   = 3'd3;
	localparam logic [2:0] ST_WB    = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_DUMP  = 3'd7;

	logic [2:0]      state_q, state_d;
	logic [NC_W-1:0] node_count_q;
	node_t           last_idx;
	node_t           r_q, d_q, v_q;
	node_t           r_d, d_d, v_d;
	logic            accept;
	logic            r_last, d_last, v_last;

	// Node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC_W'(8);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Highest active index: zero acts as one, oversize clamps to the build
	always_comb begin
		if (node_count_q == '0) begin
			last_idx = '0;
		end else if (node_count_q > NC_W'(MAX_NODES)) begin
			last_idx = NODE_W'(MAX_NODES - 1);
		end else begin
			last_idx = NODE_W'(node_count_q - 1'b1);
		end
	end

	assign accept     = item_valid && (state_q == ST_LOAD);
	assign item_stall = (state_q != ST_LOAD);
	assign r_last     = (r_q == last_idx);
	assign d_last     = (d_q == last_idx);
	assign v_last     = (v_q == last_idx);

	// Next state and command
	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		d_d      = d_q;
		v_d      = v_q;
		cmd.op   = OP_NOP;
		cmd.r    = r_q;
		cmd.d    = d_q;
		cmd.v    = v_q;
		cmd.last = r_last && d_last;
		cmd.load = accept;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last_entry) begin
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.op  = OP_CLR;
				r_d     = '0;
				d_d     = '0;
				state_d = ST_SELF;
			end
			ST_SELF: begin
				cmd.op  = OP_SELF;
				v_d     = '0;
				state_d = ST_VIA;
			end
			ST_VIA: begin
				cmd.op = OP_VIA;
				if (v_last) begin
					state_d = ST_WB;
				end else begin
					v_d = v_q + 1'b1;
				end
			end
			ST_WB: begin
				cmd.op  = OP_WB;
				state_d = ST_SELF;
				if (d_last) begin
					d_d = '0;
					if (r_last) begin
						state_d = ST_DRAIN;
					end else begin
						r_d = r_q + 1'b1;
					end
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			// let the last write-back settle the change flag
			ST_DRAIN: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.changed) begin
					state_d = ST_CLR;
				end else begin
					r_d     = '0;
					d_d     = '0;
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (stat.out_free) begin
					cmd.op = OP_DUMP;
					if (d_last) begin
						d_d = '0;
						if (r_last) begin
							state_d = ST_LOAD;
						end else begin
							r_d = r_q + 1'b1;
						end
					end else begin
						d_d = d_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			r_q     <= '0;
			d_q     <= '0;
			v_q     <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			d_q     <= d_d;
			v_q     <= v_d;
		end
	end

endmodule

[design/dvr_dpath.sv]
// ----------------------------------------------------------------------------
// dvr_dpath: route solver datapath
// Cost, distance and next-hop memories, the relax add/compare stage and the
// result register.
// ----------------------------------------------------------------------------
module dvr_dpath #(
	parameter int MAX_NODES = 8,
	parameter int COST_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dvr_pkg::NODE_W-1:0] source_node,
	input  logic [dvr_pkg::NODE_W-1:0] target_node,
	input  logic [dvr_pkg::LINK_W-1:0] link_cost,
	input  dvr_pkg::cmd_t              cmd,
	output dvr_pkg::stat_t             stat,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [dvr_pkg::NODE_W-1:0] router,
	output logic [dvr_pkg::NODE_W-1:0] destination,
	output logic [dvr_pkg::NODE_W-1:0] next_hop,
	output logic [dvr_pkg::DIST_W-1:0] distance,
	output logic                       last_result
);
	import dvr_pkg::*;

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CELLS  = MAX_NODES * MAX_NODES;
	localparam int ADDR_W = $clog2(CELLS);

	typedef logic [COST_BITS-1:0] cost_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	function automatic addr_t cell_addr(input node_t row, input node_t col);
		return ADDR_W'(row[IDX_W-1:0]) * ADDR_W'(MAX_NODES) + ADDR_W'(col[IDX_W-1:0]);
	endfunction

	cost_t            cost_mem [CELLS];
	cost_t            dist_mem [CELLS];
	logic [IDX_W-1:0] hop_mem  [CELLS];

	cost_t            cost_rd_q, dist_rd_q;
	logic [IDX_W-1:0] hop_rd_q;
	addr_t            ld_addr, wb_addr, cost_raddr, dist_raddr, hop_raddr;
	cost_t            ld_cost;
	logic             in_range, wb_en;

	op_t              op_s1;
	node_t            r_s1, d_s1, v_s1;
	logic             last_s1;

	cost_t            best_q;
	logic [IDX_W-1:0] hop_q;
	logic             upd_q, changed_q;
	cost_t            via_dist, sum_sat;
	logic [COST_BITS:0] sum;
	logic             better;

	logic             valid_q, last_q;
	node_t            router_q, destination_q, next_hop_q;
	logic [DIST_W-1:0] distance_q;

	// Matrix load: out-of-build indices are dropped, diagonal forced to zero
	assign in_range = ({1'b0, source_node} < NC_W'(MAX_NODES)) &&
	                  ({1'b0, target_node} < NC_W'(MAX_NODES));
	assign ld_addr  = cell_addr(source_node, target_node);
	assign ld_cost  = (source_node == target_node) ? '0 : COST_BITS'(link_cost);
	assign wb_addr  = cell_addr(r_s1, d_s1);
	assign wb_en    = (op_s1 == OP_WB) && upd_q;

	// Read addresses
	always_comb begin
		case (cmd.op)
			OP_VIA: begin
				cost_raddr = cell_addr(cmd.r, cmd.v);
				dist_raddr = cell_addr(cmd.v, cmd.d);
			end
			default: begin
				cost_raddr = cell_addr(cmd.r, cmd.d);
				dist_raddr = cell_addr(cmd.r, cmd.d);
			end
		endcase
		hop_raddr = cell_addr(cmd.r, cmd.d);
	end

	// Memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (cmd.load && in_range) begin
			cost_mem[ld_addr] <= ld_cost;
			dist_mem[ld_addr] <= ld_cost;
			hop_mem[ld_addr]  <= target_node[IDX_W-1:0];
		end else if (wb_en) begin
			dist_mem[wb_addr] <= best_q;
			hop_mem[wb_addr]  <= hop_q;
		end
		cost_rd_q <= cost_mem[cost_raddr];
		dist_rd_q <= dist_mem[dist_raddr];
		hop_rd_q  <= hop_mem[hop_raddr];
	end

	// Stage 1 command, aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NOP;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		r_s1    <= cmd.r;
		d_s1    <= cmd.d;
		v_s1    <= cmd.v;
		last_s1 <= cmd.last;
	end

	// Relax: via the router itself reads the in-flight distance
	assign via_dist = (v_s1 == r_s1) ? best_q : dist_rd_q;
	assign sum      = {1'b0, cost_rd_q} + {1'b0, via_dist};
	assign sum_sat  = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
	assign better   = (best_q > sum_sat);

	always_ff @(posedge clk) begin
		case (op_s1)
			OP_SELF: begin
				best_q <= dist_rd_q;
				hop_q  <= hop_rd_q;
			end
			OP_VIA: begin
				if (better) begin
					best_q <= sum_sat;
					hop_q  <= v_s1[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Entry-improved and pass-changed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q     <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			case (op_s1)
				OP_CLR:  changed_q <= 1'b0;
				OP_SELF: upd_q <= 1'b0;
				OP_VIA:  if (better) upd_q <= 1'b1;
				OP_WB:   if (upd_q) changed_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_s1 == OP_DUMP) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_s1 == OP_DUMP) begin
			router_q      <= r_s1;
			destination_q <= d_s1;
			next_hop_q    <= NODE_W'(hop_rd_q);
			distance_q    <= DIST_W'(dist_rd_q);
			last_q        <= last_s1;
		end
	end

	assign stat.out_free = (op_s1 != OP_DUMP) && (!valid_q || !result_stall);
	assign stat.changed  = changed_q;

	assign result_valid = valid_q;
	assign router       = router_q;
	assign destination  = destination_q;
	assign next_hop     = next_hop_q;
	assign distance     = distance_q;
	assign last_result  = last_q;

endmodule
